[sv/rebad_pkg.sv]
`timescale 1ns / 1ps
package rebad_pkg;

  localparam int FILT_W  = 4;
  localparam int PRESS_W = 16;
  localparam int PRE_W   = 8;
  localparam int CIDX_W  = 3;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_UP        = 3'd1,
    ACT_DOWN      = 3'd2,
    ACT_UP_FAST   = 3'd3,
    ACT_DOWN_FAST = 3'd4,
    ACT_ENTER     = 3'd5,
    ACT_BACK      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    LVL_NONE = 2'd0,
    LVL_MIN  = 2'd1,
    LVL_HALF = 2'd2,
    LVL_FULL = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    MARK_IDLE    = 2'd0,
    MARK_PENDING = 2'd1,
    MARK_FAST    = 2'd2,
    MARK_SPARE   = 2'd3
  } mark_t;

  localparam logic [CIDX_W-1:0] REG_DIR_REVERSE = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SAMPLE_PER  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FILT_ROOF   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_FILT_THRESH = 3'd3;
  localparam logic [CIDX_W-1:0] REG_FULL_LIMIT  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HALF_LIMIT  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MIN_LIMIT   = 3'd6;

  localparam logic [PRESS_W-1:0] PRESS_MAX     = 16'hFFFF;
  localparam logic [PRESS_W-1:0] DECAY_BIG_AT  = 16'd50;
  localparam logic [PRESS_W-1:0] DECAY_MID_AT  = 16'd10;
  localparam logic [PRESS_W-1:0] DECAY_BIG     = 16'd50;
  localparam logic [PRESS_W-1:0] DECAY_MID     = 16'd5;

  typedef struct packed {
    logic              en;
    logic [FILT_W-1:0] roof;
    logic [FILT_W-1:0] threshold;
  } filt_ctl_t;

endpackage

[sv/rebad_filter.sv]
`timescale 1ns / 1ps
module rebad_filter (
  input  logic                 clk,
  input  logic                 rst,
  input  rebad_pkg::filt_ctl_t ctl,
  input  logic                 pin,
  output logic                 high_next
);

  logic [rebad_pkg::FILT_W-1:0] cnt;
  logic [rebad_pkg::FILT_W-1:0] cnt_next;

  always_comb begin
    cnt_next = cnt;
    if (pin) begin
      if (cnt < ctl.roof) cnt_next = cnt + 1'b1;
    end else if (cnt != '0) begin
      cnt_next = cnt - 1'b1;
    end
  end

  assign high_next = (cnt_next > ctl.threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.en) begin
      cnt <= cnt_next;
    end
  end

endmodule

[sv/rotary_encoder_button_action_decoder.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: pin sample tick
// m_*      out  m_tvalid/m_tready  m_tdata: action and press level
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data: register write
//
// One tick per cycle while s_tready is high; the result is registered and appears in the cycle after the beat is taken.
// All state updates and the result are formed combinationally and registered when a beat is taken.
// s_tready is high while the output register is empty or being drained.
// Reset clears the filters, prescaler, press count, edge and enter state
// and loads the register defaults; cfg_ready is always high.
module rotary_encoder_button_action_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // clock_pin, data_pin, switch_pin, pad
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,   // action[2:0], press_level[4:3], pad
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rebad_pkg::CIDX_W-1:0] cfg_index,
  input  logic [15:0]                  cfg_data
);

  logic                          dir_reverse;
  logic [rebad_pkg::PRE_W-1:0]   sample_period;
  logic [rebad_pkg::FILT_W-1:0]  filt_roof;
  logic [rebad_pkg::FILT_W-1:0]  filt_threshold;
  logic [rebad_pkg::PRESS_W-1:0] full_limit;
  logic [rebad_pkg::PRESS_W-1:0] half_limit;
  logic [rebad_pkg::PRESS_W-1:0] min_limit;

  logic [rebad_pkg::PRE_W-1:0]   prescaler;
  logic [rebad_pkg::PRE_W-1:0]   prescaler_next;
  logic [rebad_pkg::PRESS_W-1:0] press_count;
  logic [rebad_pkg::PRESS_W-1:0] press_count_next;
  logic                          last_clock;
  rebad_pkg::mark_t              enter_mark;
  rebad_pkg::mark_t              enter_mark_next;
  rebad_pkg::action_t            action_next;
  rebad_pkg::level_t             level_next;
  rebad_pkg::action_t            action;
  rebad_pkg::level_t             level;

  logic                 take;
  logic                 clk_high;
  logic                 dat_high;
  logic                 cw;
  logic                 ccw;
  rebad_pkg::filt_ctl_t fctl;

  assign take      = s_tvalid & s_tready;
  assign s_tready  = ~m_tvalid | m_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, level, action};

  assign fctl.en        = take;
  assign fctl.roof      = filt_roof;
  assign fctl.threshold = filt_threshold;

  rebad_filter u_clk_filt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fctl),
    .pin       (s_tdata[0]),
    .high_next (clk_high)
  );

  rebad_filter u_dat_filt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fctl),
    .pin       (s_tdata[1]),
    .high_next (dat_high)
  );

  always_comb begin
    prescaler_next   = prescaler;
    press_count_next = press_count;
    if (prescaler != '0) begin
      prescaler_next = prescaler - 1'b1;
    end else begin
      prescaler_next = sample_period;
      if (s_tdata[2]) begin
        if (press_count != rebad_pkg::PRESS_MAX) press_count_next = press_count + 1'b1;
      end else if (press_count > rebad_pkg::DECAY_BIG_AT) begin
        press_count_next = press_count - rebad_pkg::DECAY_BIG;
      end else if (press_count > rebad_pkg::DECAY_MID_AT) begin
        press_count_next = press_count - rebad_pkg::DECAY_MID;
      end else if (press_count != '0) begin
        press_count_next = press_count - 1'b1;
      end
    end

    if (press_count_next > full_limit) begin
      level_next = rebad_pkg::LVL_FULL;
    end else if (press_count_next > half_limit) begin
      level_next = rebad_pkg::LVL_HALF;
    end else if (press_count_next > min_limit) begin
      level_next = rebad_pkg::LVL_MIN;
    end else begin
      level_next = rebad_pkg::LVL_NONE;
    end

    cw  = ~last_clock & clk_high & (dat_high != dir_reverse);
    ccw = ~last_clock & clk_high & (dat_high == dir_reverse);

    action_next     = rebad_pkg::ACT_NONE;
    enter_mark_next = enter_mark;
    if (cw) begin
      if (level_next != rebad_pkg::LVL_NONE) begin
        action_next     = rebad_pkg::ACT_UP_FAST;
        enter_mark_next = rebad_pkg::MARK_FAST;
      end else begin
        action_next = rebad_pkg::ACT_UP;
      end
    end
    if (ccw) begin
      if (level_next != rebad_pkg::LVL_NONE) begin
        action_next     = rebad_pkg::ACT_DOWN_FAST;
        enter_mark_next = rebad_pkg::MARK_FAST;
      end else begin
        action_next = rebad_pkg::ACT_DOWN;
      end
    end

    if (level_next == rebad_pkg::LVL_FULL) begin
      action_next = rebad_pkg::ACT_BACK;
    end else if (level_next != rebad_pkg::LVL_NONE) begin
      if (enter_mark_next == rebad_pkg::MARK_IDLE) enter_mark_next = rebad_pkg::MARK_PENDING;
    end else begin
      if (enter_mark_next == rebad_pkg::MARK_PENDING) action_next = rebad_pkg::ACT_ENTER;
      enter_mark_next = rebad_pkg::MARK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_reverse    <= 1'b0;
      sample_period  <= 8'd5;
      filt_roof      <= 4'd10;
      filt_threshold <= 4'd3;
      full_limit     <= 16'd1000;
      half_limit     <= 16'd100;
      min_limit      <= 16'd5;
    end else if (cfg_valid & cfg_ready) begin
      case (cfg_index)
        rebad_pkg::REG_DIR_REVERSE: dir_reverse    <= cfg_data[0];
        rebad_pkg::REG_SAMPLE_PER:  sample_period  <= cfg_data[rebad_pkg::PRE_W-1:0];
        rebad_pkg::REG_FILT_ROOF:   filt_roof      <= cfg_data[rebad_pkg::FILT_W-1:0];
        rebad_pkg::REG_FILT_THRESH: filt_threshold <= cfg_data[rebad_pkg::FILT_W-1:0];
        rebad_pkg::REG_FULL_LIMIT:  full_limit     <= cfg_data;
        rebad_pkg::REG_HALF_LIMIT:  half_limit     <= cfg_data;
        rebad_pkg::REG_MIN_LIMIT:   min_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler   <= '0;
      press_count <= '0;
      last_clock  <= 1'b0;
      enter_mark  <= rebad_pkg::MARK_IDLE;
      m_tvalid    <= 1'b0;
    end else begin
      if (take) begin
        prescaler   <= prescaler_next;
        press_count <= press_count_next;
        last_clock  <= clk_high;
        enter_mark  <= enter_mark_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      action <= action_next;
      level  <= level_next;
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    rebad_pkg::action_t act;
    rebad_pkg::level_t  lvl;
  } decode_t;

  typedef struct packed {
    logic               c;
    logic               d;
    logic               sw;
    logic               typed;
    rebad_pkg::action_t act;
    rebad_pkg::level_t  lvl;
  } step_t;

  typedef struct packed {
    logic        dir;
    logic [7:0]  period;
    logic [3:0]  roof;
    logic [3:0]  thr;
    logic [15:0] full;
    logic [15:0] half;
    logic [15:0] min_lim;
  } setup_t;

  localparam setup_t SETUP_QUICK   = '{1'b0, 8'd0,   4'd2,  4'd0,  16'd4,     16'd2,     16'd0};
  localparam setup_t SETUP_REVERSE = '{1'b1, 8'd1,   4'd10, 4'd3,  16'd40,    16'd15,    16'd5};
  localparam setup_t SETUP_EXTREME = '{1'b0, 8'd255, 4'd15, 4'd15, 16'd65535, 16'd0,     16'd65535};
  localparam setup_t SETUP_LOWROOF = '{1'b1, 8'd3,   4'd1,  4'd0,  16'd100,   16'd30,    16'd2};
  localparam setup_t SETUP_NOROOF  = '{1'b0, 8'd0,   4'd0,  4'd0,  16'd60,    16'd20,    16'd0};
  localparam setup_t SETUP_SATURATE = '{1'b1, 8'd0,  4'd4,  4'd1,  16'd65534, 16'd65533, 16'd65532};
  localparam setup_t SETUP_DEFAULT = '{1'b0, 8'd5,   4'd10, 4'd3,  16'd1000,  16'd100,   16'd5};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [7:0]                   m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [rebad_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [15:0]                  cfg_data = '0;

  rotary_encoder_button_action_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("rotary_encoder_button_action_decoder: mismatch");
    $finish;
  end

  setup_t           knobs = SETUP_DEFAULT;
  logic [3:0]       clk_filt = '0;
  logic [3:0]       dat_filt = '0;
  logic [7:0]       presc = '0;
  logic [15:0]      press = '0;
  logic             prev_clk_now = 1'b0;
  rebad_pkg::mark_t mark = rebad_pkg::MARK_IDLE;

  decode_t     due_decodes [$];
  int          mismatches = 0;
  int          rx_hold = 0;
  bit          idle_on = 1'b1;

  step_t script [24] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b1, 1'b1, 1'b0, 1'b1, rebad_pkg::ACT_UP,    rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b1, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b1, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b1, rebad_pkg::ACT_ENTER, rebad_pkg::LVL_NONE},
    '{1'b1, 1'b1, 1'b1, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b1, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b1, 1'b0, 1'b1, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b1, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b1, 1'b1, rebad_pkg::ACT_BACK,  rebad_pkg::LVL_FULL},
    '{1'b1, 1'b1, 1'b1, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b1, 1'b1, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b1, 1'b1, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b1, 1'b1, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b0, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE},
    '{1'b1, 1'b0, 1'b0, 1'b0, rebad_pkg::ACT_NONE,  rebad_pkg::LVL_NONE}
  };

  function automatic logic [3:0] filter_next(input logic [3:0] cnt, input logic pin);
    if (pin) return (cnt < knobs.roof) ? cnt + 4'd1 : cnt;
    return (cnt != 4'd0) ? cnt - 4'd1 : cnt;
  endfunction

  function automatic decode_t decode_tick(input logic c, input logic d, input logic sw);
    decode_t r;
    logic    clk_now;
    logic    dat_now;
    r.act = rebad_pkg::ACT_NONE;
    clk_filt = filter_next(clk_filt, c);
    dat_filt = filter_next(dat_filt, d);
    if (presc != 8'd0) begin
      presc = presc - 8'd1;
    end else begin
      if (sw) begin
        if (press != rebad_pkg::PRESS_MAX) press = press + 16'd1;
      end else if (press > rebad_pkg::DECAY_BIG_AT) begin
        press = press - rebad_pkg::DECAY_BIG;
      end else if (press > rebad_pkg::DECAY_MID_AT) begin
        press = press - rebad_pkg::DECAY_MID;
      end else if (press != 16'd0) begin
        press = press - 16'd1;
      end
      presc = knobs.period;
    end
    if (press > knobs.full) r.lvl = rebad_pkg::LVL_FULL;
    else if (press > knobs.half) r.lvl = rebad_pkg::LVL_HALF;
    else if (press > knobs.min_lim) r.lvl = rebad_pkg::LVL_MIN;
    else r.lvl = rebad_pkg::LVL_NONE;
    clk_now = clk_filt > knobs.thr;
    dat_now = dat_filt > knobs.thr;
    if (!prev_clk_now && clk_now) begin
      if (r.lvl != rebad_pkg::LVL_NONE) begin
        r.act = (dat_now != knobs.dir) ? rebad_pkg::ACT_UP_FAST : rebad_pkg::ACT_DOWN_FAST;
        mark = rebad_pkg::MARK_FAST;
      end else begin
        r.act = (dat_now != knobs.dir) ? rebad_pkg::ACT_UP : rebad_pkg::ACT_DOWN;
      end
    end
    prev_clk_now = clk_now;
    if (r.lvl == rebad_pkg::LVL_FULL) begin
      r.act = rebad_pkg::ACT_BACK;
    end else if (r.lvl != rebad_pkg::LVL_NONE) begin
      if (mark == rebad_pkg::MARK_IDLE) mark = rebad_pkg::MARK_PENDING;
    end else begin
      if (mark == rebad_pkg::MARK_PENDING) r.act = rebad_pkg::ACT_ENTER;
      mark = rebad_pkg::MARK_IDLE;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_tick(input logic c, input logic d, input logic sw,
                           input logic typed, input decode_t want);
    decode_t predicted;
    int      gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, sw, d, c};
    do @(posedge clk); while (!s_tready);
    predicted = decode_tick(c, d, sw);
    due_decodes.push_back(typed ? want : predicted);
  endtask

  task automatic load_setup(input setup_t s);
    logic [rebad_pkg::CIDX_W-1:0] order [7] = '{
      rebad_pkg::REG_DIR_REVERSE, rebad_pkg::REG_SAMPLE_PER, rebad_pkg::REG_FILT_ROOF,
      rebad_pkg::REG_FILT_THRESH, rebad_pkg::REG_FULL_LIMIT, rebad_pkg::REG_HALF_LIMIT,
      rebad_pkg::REG_MIN_LIMIT};
    s_tvalid <= 1'b0;
    while (due_decodes.size() != 0) @(posedge clk);
    @(posedge clk);
    foreach (order[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      case (order[i])
        rebad_pkg::REG_DIR_REVERSE: cfg_data <= 16'(s.dir);
        rebad_pkg::REG_SAMPLE_PER:  cfg_data <= 16'(s.period);
        rebad_pkg::REG_FILT_ROOF:   cfg_data <= 16'(s.roof);
        rebad_pkg::REG_FILT_THRESH: cfg_data <= 16'(s.thr);
        rebad_pkg::REG_FULL_LIMIT:  cfg_data <= s.full;
        rebad_pkg::REG_HALF_LIMIT:  cfg_data <= s.half;
        default:                    cfg_data <= s.min_lim;
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    knobs = s;
  endtask

  // Turn the encoder in detents and hold the switch for long and short stretches,
  // with the odd noisy tick.
  task automatic drive_random(input int count);
    int   sw_run;
    int   enc_run;
    logic sw_lvl;
    logic c_lvl;
    logic d_lvl;
    sw_run  = 0;
    enc_run = 0;
    sw_lvl  = 1'($urandom_range(0, 1));
    c_lvl   = 1'b0;
    d_lvl   = 1'b0;
    repeat (count) begin
      if (sw_run == 0) begin
        sw_lvl = !sw_lvl;
        sw_run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
      end
      if (enc_run == 0) begin
        c_lvl = !c_lvl;
        if (!c_lvl) d_lvl = 1'($urandom_range(0, 1));
        enc_run = $urandom_range(1, 10);
      end
      if ($urandom_range(0, 9) == 0)
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      else
        send_tick(c_lvl, d_lvl, sw_lvl, 1'b0, '0);
      sw_run--;
      enc_run--;
    end
  endtask

  always @(posedge clk) begin
    decode_t head;
    if (!rst && m_tvalid && m_tready) begin
      if (due_decodes.size() == 0) begin
        flag_mismatch("unexpected beat", m_tdata, 0);
      end else begin
        head = due_decodes.pop_front();
        if (m_tdata[2:0] != head.act) flag_mismatch("action", m_tdata[2:0], head.act);
        if (m_tdata[4:3] != head.lvl) flag_mismatch("press level", m_tdata[4:3], head.lvl);
      end
    end
    if (rx_hold != 0) rx_hold--;
    else if (idle_on && $urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 17);
    m_tready <= (rx_hold == 0);
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    load_setup(SETUP_QUICK);
    foreach (script[i])
      send_tick(script[i].c, script[i].d, script[i].sw, script[i].typed,
                decode_t'{script[i].act, script[i].lvl});
    drive_random(50);

    load_setup(SETUP_REVERSE);
    drive_random(60);

    load_setup(SETUP_EXTREME);
    drive_random(40);
    // fill both filters to the top before the roof comes down
    repeat (16) send_tick(1'b1, 1'b1, 1'b1, 1'b0, '0);

    load_setup(SETUP_LOWROOF);
    drive_random(60);

    load_setup(SETUP_NOROOF);
    drive_random(40);

    idle_on = 1'b0;
    load_setup(SETUP_SATURATE);
    repeat (40)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, '0);
    repeat (30)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);

    load_setup(SETUP_DEFAULT);
    drive_random(40);

    s_tvalid <= 1'b0;
    while (due_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("rotary_encoder_button_action_decoder: match");
    else
      $display("rotary_encoder_button_action_decoder: mismatch");
    $finish;
  end

endmodule

[sim.f]
sv/rebad_pkg.sv
sv/rebad_filter.sv
sv/rotary_encoder_button_action_decoder.sv
test/tb.sv
